// ----- design/bfp_pkg.sv -----
// Package for the bitstream field packer: sizes, command and state codes,
// request and result structs, and the internal control structs.
// Depends on nothing; every design file imports it.
`default_nettype none

package bfp_pkg;

  localparam int STORE_BYTES    = 1024;
  localparam int MAX_FIELD_BITS = 32;

  localparam int POS_W     = 14;
  localparam int IDX_W     = POS_W - 3;
  localparam int ADDR_W    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int LIMIT_W   = 11;
  localparam int CNT_W     = 6;
  localparam int VAL_W     = 32;
  localparam int BIT_IDX_W = $clog2(VAL_W);
  localparam int PADDR_W   = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  // Register index as decoded from paddr[2].
  localparam logic [0:0] REG_BYTE_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SETPOS = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_BITS,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_e_t           command;
    logic [VAL_W-1:0] field_value;
    logic [CNT_W-1:0] bit_count;
    logic [POS_W-1:0] new_position;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [POS_W-1:0] position_after;
    logic             hit_limit;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic load;
    logic step;
    logic gather;
  } ser_ctl_t;

  typedef struct packed {
    logic out_bit;
    logic last;
  } ser_sts_t;

endpackage

`default_nettype wire

// ----- design/bfp_store.sv -----
// Byte store of the bitstream field packer: one write port, one read port
// with registered read data. Depends on bfp_pkg.
`default_nettype none

module bfp_store
  import bfp_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_wr_t           wr,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic [7:0]             rdata
);

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/bfp_serdes.sv -----
// Bit-serial field unit: holds the field being written and its remaining
// bit count, and gathers read bits by shifting them in one per cycle while stepped.
// Depends on bfp_pkg.
`default_nettype none

module bfp_serdes
  import bfp_pkg::*;
(
  input  wire logic             clk,
  input  wire ser_ctl_t         ctl,
  input  wire logic [VAL_W-1:0] load_value,
  input  wire logic [CNT_W-1:0] load_count,
  input  wire logic             in_bit,
  output ser_sts_t              sts,
  output logic [VAL_W-1:0]      gathered
);

  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [VAL_W-1:0]     rd_r, rd_nxt;
  logic [BIT_IDX_W-1:0] sel;

  // The current bit is bit count-1 of the field, most significant first.
  assign sel          = BIT_IDX_W'(cnt_r - CNT_W'(1));
  assign sts.out_bit  = val_r[sel];
  assign sts.last     = (cnt_r == CNT_W'(1));
  assign gathered     = rd_r;

  always_comb begin
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (ctl.load) begin
      val_nxt = load_value;
      cnt_nxt = load_count;
      rd_nxt  = '0;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (ctl.gather) begin
        rd_nxt = {rd_r[VAL_W-2:0], in_bit};
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
    rd_r  <= rd_nxt;
  end

endmodule

`default_nettype wire

// ----- design/bitstream_field_packer.sv -----
// Top level of the bitstream field packer: command port, APB register port,
// control sequencer and bit position. Depends on bfp_pkg, bfp_store, bfp_serdes.
//
//   Channel   Ports                              Direction  Handshake
//   command   start, busy, in_req                in         start && !busy
//   result    out_strobe, out_res                out        out_strobe, one cycle
//   register  psel penable pwrite paddr pwdata   in/out     APB, pready tied high
//             prdata pready
//
// A write or read request with a nonzero bit count fetches each byte that it
// touches through the registered read port, handles its bits one at a time and
// ends with the result strobe. A write that reaches the byte limit stops at the
// limit check made before each of its bits, then gives its result strobe.
// Set-position, unused commands and zero-count requests go straight to the result
// strobe. busy is low again in the cycle after the strobe.
// After reset the store is cleared one byte per cycle, which holds busy high
// for the whole pass; register writes are taken during that pass.
// The receiver of results cannot stall the block.
`default_nettype none

module bitstream_field_packer
  import bfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Command request channel
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_req,
  // Result channel
  output logic                    out_strobe,
  output out_item_t               out_res,
  // Register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  cmd_e_t            cmd_r, cmd_nxt;
  logic              hit_r, hit_nxt;
  logic              fresh_r, fresh_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] eff_lim_r;

  logic [IDX_W-1:0]  idx;
  logic [2:0]        bitsel;
  logic              in_store;
  logic [7:0]        cur_byte;
  logic [7:0]        new_byte;
  logic              cur_bit;
  logic [CNT_W-1:0]  cnt_sat;
  logic              accept;
  logic              reg_wr;

  mem_wr_t           mem_wr;
  logic [7:0]        rdata;
  ser_ctl_t          ser_ctl;
  ser_sts_t          ser_sts;
  logic [VAL_W-1:0]  gathered;

  // ---------------------------------------------------------------------------
  // Register port. The effective limit is the smaller of the programmed limit
  // and the store size, worked out once when the register is written.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready &&
                  (paddr[2:2] == REG_BYTE_LIMIT);
  assign prdata = (paddr[2:2] == REG_BYTE_LIMIT) ? 32'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RESET;
      eff_lim_r <= (32'(LIMIT_RESET) > STORE_BYTES) ? LIMIT_W'(STORE_BYTES) : LIMIT_RESET;
    end else if (reg_wr) begin
      limit_r   <= pwdata[LIMIT_W-1:0];
      eff_lim_r <= (32'(pwdata[LIMIT_W-1:0]) > STORE_BYTES) ? LIMIT_W'(STORE_BYTES)
                                                            : pwdata[LIMIT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath around the current byte. The byte is cached in byte_r while the
  // bits of one byte are handled; on the first bit after a fetch it comes
  // straight from the store's read register. Bytes past the end of the store
  // read as zero.
  // ---------------------------------------------------------------------------
  assign idx      = pos_r[POS_W-1:3];
  assign bitsel   = pos_r[2:0];
  assign in_store = (32'(idx) < STORE_BYTES);
  assign cur_byte = fresh_r ? rdata : byte_r;
  assign cur_bit  = in_store && cur_byte[bitsel];
  assign new_byte = cur_byte | ({7'b0, ser_sts.out_bit} << bitsel);
  assign cnt_sat  = (in_req.bit_count > CNT_W'(MAX_FIELD_BITS)) ? CNT_W'(MAX_FIELD_BITS)
                                                               : in_req.bit_count;
  assign accept   = start && !busy;

  bfp_store u_store (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (ADDR_W'(idx)),
    .rdata (rdata)
  );

  bfp_serdes u_serdes (
    .clk        (clk),
    .ctl        (ser_ctl),
    .load_value (in_req.field_value),
    .load_count (cnt_sat),
    .in_bit     (cur_bit),
    .sts        (ser_sts),
    .gathered   (gathered)
  );

  // ---------------------------------------------------------------------------
  // Sequencer. A write checks the limit before every bit, ORs the bit into the
  // cached byte and writes the byte back when it leaves the byte or finishes.
  // A limit stop can only happen on the first bit this request handles in a byte
  // if the limit is not rewritten meanwhile, so nothing is then pending in the cache.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      pos_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pos_r     <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    hit_r   <= hit_nxt;
    fresh_r <= fresh_nxt;
    byte_r  <= byte_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pos_nxt     = pos_r;
    cmd_nxt     = cmd_r;
    hit_nxt     = hit_r;
    fresh_nxt   = 1'b0;
    byte_nxt    = byte_r;
    mem_wr      = '{we: 1'b0, addr: ADDR_W'(idx), data: new_byte};
    ser_ctl     = '{load: 1'b0, step: 1'b0, gather: 1'b0};
    busy        = 1'b1;
    out_strobe  = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_wr      = '{we: 1'b1, addr: clr_cnt_r, data: 8'h00};
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (32'(clr_cnt_r) == STORE_BYTES - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          cmd_nxt      = in_req.command;
          hit_nxt      = 1'b0;
          ser_ctl.load = 1'b1;
          state_nxt    = ST_DONE;
          case (in_req.command)
            CMD_WRITE, CMD_READ: begin
              if (cnt_sat != '0) begin
                state_nxt = ST_FETCH;
              end
            end
            CMD_SETPOS: begin
              pos_nxt = in_req.new_position;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        fresh_nxt = 1'b1;
        state_nxt = ST_BITS;
      end
      ST_BITS: begin
        if (cmd_r == CMD_WRITE && idx >= eff_lim_r) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ser_ctl.step   = 1'b1;
          ser_ctl.gather = (cmd_r == CMD_READ);
          pos_nxt        = pos_r + POS_W'(1);
          byte_nxt       = (cmd_r == CMD_WRITE) ? new_byte : cur_byte;
          if (cmd_r == CMD_WRITE && (bitsel == 3'd7 || ser_sts.last)) begin
            mem_wr.we = 1'b1;
          end
          if (ser_sts.last) begin
            state_nxt = ST_DONE;
          end else if (bitsel == 3'd7) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        out_strobe = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_res.read_value     = (cmd_r == CMD_READ) ? gathered : '0;
  assign out_res.position_after = pos_r;
  assign out_res.hit_limit      = hit_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not make the block busy");

  a_strobe_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy && !out_strobe)
    else $error("result strobe not followed by an idle cycle");

  a_write_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr.we && state_r == ST_BITS) |-> (idx < eff_lim_r && cmd_r == CMD_WRITE))
    else $error("store written outside the byte limit");

  a_hit_only_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.hit_limit) |-> (cmd_r == CMD_WRITE))
    else $error("limit flag raised on a request other than a write");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (busy && !out_strobe))
    else $error("request possible during the clearing pass");

endmodule

`default_nettype wire
